// ===== design/pie_pkg.sv =====
// Package for the palette index encoder: sizes, command and status types.
// Used by every module of the block; depends on nothing.
package pie_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int STATE_WIDTH   = 16;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int OUT_IDX_W     = 8;
  localparam int OUT_CNT_W     = 9;
  localparam int IN_STATE_W    = 16;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } pie_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } pie_stat_t;

endpackage

// ===== design/pie_if.sv =====
// Channel interfaces of the palette index encoder: input items and results.
// Depends on pie_pkg for the field widths.
interface pie_in_if import pie_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  first_of_section;
  logic [IN_STATE_W-1:0] block_state;

  modport source (output valid, output first_of_section, output block_state, input ready);
  modport sink   (input valid, input first_of_section, input block_state, output ready);
endinterface

interface pie_out_if import pie_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] palette_index;
  logic                 is_new_entry;
  logic                 overflow;
  logic [OUT_CNT_W-1:0] entries_used;

  modport source (output valid, output palette_index, output is_new_entry, output overflow,
                  output entries_used, input ready);
  modport sink   (input valid, input palette_index, input is_new_entry, input overflow,
                  input entries_used, output ready);
endinterface

// ===== design/pie_ctrl.sv =====
// Controller of the palette index encoder: accepts an item, steps the search
// and commits the result. Depends on pie_pkg.
module pie_ctrl import pie_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pie_stat_t stat,
  output pie_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hit || stat.scan_end) begin
          if (stat.out_free) begin
            cmd.commit = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/pie_dp.sv =====
// Datapath of the palette index encoder: palette memory, entry count, search
// pointer, comparator and result register. Depends on pie_pkg and pie_out_if.
module pie_dp import pie_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  first_of_section,
  input  logic [IN_STATE_W-1:0] block_state,
  input  pie_cmd_t              cmd,
  output pie_stat_t             stat,
  pie_out_if.source             result
);

  logic [STATE_WIDTH-1:0] palette_mem [PALETTE_DEPTH];
  logic [STATE_WIDTH-1:0] rd_q;
  logic [STATE_WIDTH-1:0] value;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       scan;
  logic [CNT_W-1:0]       cmp_idx;
  logic                   cmp_vld;
  logic                   out_valid;
  logic                   hit;
  logic                   has_room;
  logic                   append;

  assign hit           = cmp_vld && (rd_q == value);
  assign has_room      = count < CNT_W'(PALETTE_DEPTH);
  assign append        = cmd.commit && !hit && has_room;
  assign stat.hit      = hit;
  assign stat.scan_end = (scan == count);
  assign stat.out_free = !out_valid || result.ready;
  assign result.valid  = out_valid;

  always_ff @(posedge clk) begin
    if (append) begin
      palette_mem[count[IDX_W-1:0]] <= value;
    end
    if (cmd.step) begin
      rd_q <= palette_mem[scan[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan      <= '0;
      cmp_idx   <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan    <= '0;
        cmp_vld <= 1'b0;
        if (first_of_section) begin
          count <= '0;
        end
      end else if (cmd.step) begin
        scan    <= scan + CNT_W'(1);
        cmp_idx <= scan;
        cmp_vld <= 1'b1;
      end
      if (append) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= block_state[STATE_WIDTH-1:0];
    end
    if (cmd.commit) begin
      if (hit) begin
        result.palette_index <= cmp_idx[OUT_IDX_W-1:0];
        result.is_new_entry  <= 1'b0;
        result.overflow      <= 1'b0;
        result.entries_used  <= count[OUT_CNT_W-1:0];
      end else if (has_room) begin
        result.palette_index <= count[OUT_IDX_W-1:0];
        result.is_new_entry  <= 1'b1;
        result.overflow      <= 1'b0;
        result.entries_used  <= OUT_CNT_W'(count + CNT_W'(1));
      end else begin
        result.palette_index <= '0;
        result.is_new_entry  <= 1'b0;
        result.overflow      <= 1'b1;
        result.entries_used  <= count[OUT_CNT_W-1:0];
      end
    end
  end

endmodule

// ===== design/palette_index_encoder_core.sv =====
// Top level of the palette index encoder.
// Depends on pie_pkg, pie_if, pie_ctrl and pie_dp.
//
// The item channel carries a block-state value and a first-of-section flag; the
// result channel returns its palette index, a new-entry flag, an overflow flag
// and the number of palette entries in use. Both use valid/ready transfers.
// The palette holds distinct values in order of first appearance. A value seen
// before returns its stored index; a new one is appended, or raises overflow
// with index 0 when the palette is full. A first-of-section item empties it.
// One item is processed at a time. After a transfer on the item channel the
// block reads one palette entry per cycle from its single memory port until it
// finds the value or reaches the entry count, and then registers the result;
// at most 256 entries are compared. The next item is taken in the cycle after
// the result is registered.
// A result waits in the output register while the receiver stalls; a further
// item may still be accepted and searched, and its result is held back until
// the register is free. Reset empties the palette and drops any pending result;
// no clearing pass is needed, since only entries below the count are searched.
module palette_index_encoder_core import pie_pkg::*; (
  input logic       clk,
  input logic       rst,
  pie_in_if.sink    item,
  pie_out_if.source result
);

  pie_cmd_t  cmd;
  pie_stat_t stat;

  pie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pie_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .first_of_section (item.first_of_section),
    .block_state      (item.block_state),
    .cmd              (cmd),
    .stat             (stat),
    .result           (result)
  );

endmodule

// ===== design/pie_chk.sv =====
// Port-level checks on the palette index encoder's result channel.
// Depends on pie_pkg; bound to palette_index_encoder_core below.
module pie_chk import pie_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_IDX_W-1:0] palette_index,
  input logic                 is_new_entry,
  input logic                 overflow,
  input logic [OUT_CNT_W-1:0] entries_used
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(palette_index) && $stable(entries_used))
    else $error("result changed during a stalled transfer");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new_entry && overflow))
    else $error("new entry and overflow both set");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> palette_index == '0 && entries_used == OUT_CNT_W'(PALETTE_DEPTH))
    else $error("overflow without a full palette or with a non-zero index");

  a_append: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new_entry |-> entries_used == {1'b0, palette_index} + OUT_CNT_W'(1))
    else $error("appended index does not match the entry count");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind palette_index_encoder_core pie_chk u_pie_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .palette_index (result.palette_index),
  .is_new_entry  (result.is_new_entry),
  .overflow      (result.overflow),
  .entries_used  (result.entries_used)
);
